/* rtl/core/bbn_pkg.sv */
// Shared types and default constants for the vertex bounding box normaliser.
// No dependencies; imported by every module of the block.

package bbn_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Frame sequencer states
    typedef enum logic [2:0] {
        ST_RUN,
        ST_MERGE,
        ST_START,
        ST_DIV,
        ST_OUT
    } bbn_state_t;

    // Per-axis lane control
    typedef struct packed {
        logic upd;
        logic clr;
    } lane_ctrl_t;

endpackage

/* rtl/core/vertex_bounding_box_normaliser.sv */
// Top level of the vertex bounding box normaliser: three axis lanes, merge, divider.
// Depends on bbn_pkg, bbn_axis_lane, bbn_merge and bbn_recip_div.
//
// Usage:
//   Stream one vertex per request on the s_ channel: x, y, z packed in s_tdata,
//   s_tlast high on the final vertex of a frame. Each axis lane keeps a running
//   min and max seeded at zero, so the box always holds the origin.
//   After the last vertex the block emits one request on the m_ channel: the box,
//   its center and the reciprocal of its longest side; m_tuser flags a zero box
//   (reciprocal then reads zero).
// Throughput: one vertex per cycle inside a frame. The last vertex closes the
//   input; the sequencer then steps through ST_MERGE and ST_START to ST_OUT,
//   via ST_DIV for a nonzero box while the one-bit-per-cycle restoring divider runs.
//   s_tready stays low from the last vertex until the result is taken.
// Stall: with m_tready low, hold m_tvalid and m_tdata; the lanes keep the box
//   until the result is taken, then clear for the next frame.
// Reset: aresetn low clears the lanes to zero and returns to accepting vertices.

module vertex_bounding_box_normaliser
    import bbn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int IN_W       = 3 * COORD_WIDTH,
    localparam int IN_TW      = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W      = 10 * COORD_WIDTH - 6,
    localparam int OUT_TW     = ((OUT_W + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    // s_tdata fields, low bit up: pos_x, pos_y, pos_z
    input  logic [IN_TW-1:0]  s_tdata,
    input  logic              s_tlast,
    input  logic              s_tvalid,
    output logic              s_tready,
    // m_tdata fields, low bit up: box_min_x, box_min_y, box_min_z, box_max_x,
    // box_max_y, box_max_z, mid_x, mid_y, mid_z, scale_recip
    output logic [OUT_TW-1:0] m_tdata,
    // m_tuser fields, low bit up: extent_zero
    output logic              m_tuser,
    output logic              m_tvalid,
    input  logic              m_tready
);

    localparam int CW = COORD_WIDTH;

    bbn_state_t state_reg, state_next;
    lane_ctrl_t lane_ctrl;

    logic s_acc;
    logic m_acc;
    logic merge_load;
    logic div_start;
    logic div_done;

    logic signed [CW-1:0] min_x, min_y, min_z;
    logic        [CW-2:0] max_x, max_y, max_z;
    logic        [CW-1:0] ext_x, ext_y, ext_z;
    logic signed [CW-2:0] mid_x, mid_y, mid_z;
    logic        [CW-1:0] longest;
    logic                 is_zero;
    logic        [CW-1:0] quot;

    logic [OUT_W-CW-1:0]  box_reg;
    logic [CW-1:0]        scale_reg;
    logic                 zero_reg;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // Lanes: one per axis, each sees its own coordinate
    assign lane_ctrl.upd = s_acc;
    assign lane_ctrl.clr = m_acc;

    bbn_axis_lane #(.COORD_WIDTH(CW)) u_lane_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lane_ctrl),
        .pos     ($signed(s_tdata[CW-1:0])),
        .box_min (min_x),
        .box_max (max_x),
        .extent  (ext_x),
        .mid     (mid_x)
    );

    bbn_axis_lane #(.COORD_WIDTH(CW)) u_lane_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lane_ctrl),
        .pos     ($signed(s_tdata[2*CW-1:CW])),
        .box_min (min_y),
        .box_max (max_y),
        .extent  (ext_y),
        .mid     (mid_y)
    );

    bbn_axis_lane #(.COORD_WIDTH(CW)) u_lane_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (lane_ctrl),
        .pos     ($signed(s_tdata[3*CW-1:2*CW])),
        .box_min (min_z),
        .box_max (max_z),
        .extent  (ext_z),
        .mid     (mid_z)
    );

    bbn_merge #(.COORD_WIDTH(CW)) u_merge (
        .aclk    (aclk),
        .load    (merge_load),
        .ext_x   (ext_x),
        .ext_y   (ext_y),
        .ext_z   (ext_z),
        .longest (longest),
        .is_zero (is_zero)
    );

    bbn_recip_div #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (longest),
        .done    (div_done),
        .quot    (quot)
    );

    // Frame sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        merge_load = 1'b0;
        div_start  = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                // lanes hold the closed box; take the longest side
                merge_load = 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                if (is_zero) begin
                    state_next = ST_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Result registers: capture the box once, the reciprocal when it is known
    always_ff @(posedge aclk) begin
        if (merge_load) begin
            box_reg <= {mid_z, mid_y, mid_x, max_z, max_y, max_x, min_z, min_y, min_x};
        end
        if (state_reg == ST_START && is_zero) begin
            scale_reg <= '0;
            zero_reg  <= 1'b1;
        end else if (state_reg == ST_DIV && div_done) begin
            scale_reg <= quot;
            zero_reg  <= 1'b0;
        end
    end

    assign m_tdata = OUT_TW'({scale_reg, box_reg});
    assign m_tuser = zero_reg;

endmodule

/* rtl/core/bbn_axis_lane.sv */
// One axis lane: running min/max of a coordinate, with extent and center.
// Depends on bbn_pkg (lane_ctrl_t).

module bbn_axis_lane
    import bbn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lane_ctrl_t                    ctrl,
    input  logic signed [COORD_WIDTH-1:0] pos,
    output logic signed [COORD_WIDTH-1:0] box_min,
    output logic        [COORD_WIDTH-2:0] box_max,
    output logic        [COORD_WIDTH-1:0] extent,
    output logic signed [COORD_WIDTH-2:0] mid
);

    logic signed [COORD_WIDTH-1:0] min_reg;
    logic        [COORD_WIDTH-2:0] max_reg;
    logic signed [COORD_WIDTH-1:0] max_s;
    logic signed [COORD_WIDTH-1:0] sum;

    assign max_s = $signed({1'b0, max_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clr) begin
            min_reg <= '0;
            max_reg <= '0;
        end else if (ctrl.upd) begin
            if (pos < min_reg) begin
                min_reg <= pos;
            end
            if (pos > max_s) begin
                max_reg <= pos[COORD_WIDTH-2:0];
            end
        end
    end

    // max - min always lands in [0, 2^W - 1], so modulo-W arithmetic is exact
    assign extent  = {1'b0, max_reg} - $unsigned(min_reg);
    // min + max fits W signed bits; drop bit 0 for a floor half
    assign sum     = max_s + min_reg;
    assign mid     = $signed(sum[COORD_WIDTH-1:1]);
    assign box_min = min_reg;
    assign box_max = max_reg;

endmodule

/* rtl/core/bbn_merge.sv */
// Merge stage: picks the longest of the three lane extents and flags a zero box.
// Depends on bbn_pkg for the default width.

module bbn_merge
    import bbn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   load,
    input  logic [COORD_WIDTH-1:0] ext_x,
    input  logic [COORD_WIDTH-1:0] ext_y,
    input  logic [COORD_WIDTH-1:0] ext_z,
    output logic [COORD_WIDTH-1:0] longest,
    output logic                   is_zero
);

    logic [COORD_WIDTH-1:0] ext_xy;
    logic [COORD_WIDTH-1:0] ext_max;
    logic [COORD_WIDTH-1:0] longest_reg;
    logic                   is_zero_reg;

    always_comb begin
        ext_xy  = (ext_y > ext_x) ? ext_y : ext_x;
        ext_max = (ext_z > ext_xy) ? ext_z : ext_xy;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            longest_reg <= ext_max;
            is_zero_reg <= (ext_max == '0);
        end
    end

    assign longest = longest_reg;
    assign is_zero = is_zero_reg;

endmodule

/* rtl/core/bbn_recip_div.sv */
// Restoring divider, one quotient bit per cycle: floor(2^(2*FRAC_BITS) / divisor),
// saturated to COORD_WIDTH bits. Depends on bbn_pkg for defaults.

module bbn_recip_div
    import bbn_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [COORD_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [COORD_WIDTH-1:0] quot
);

    localparam int QW    = 2 * FRAC_BITS + 1;
    localparam int QRW   = (QW > COORD_WIDTH) ? QW : COORD_WIDTH + 1;
    localparam int CNT_W = $clog2(QW + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [COORD_WIDTH-1:0] div_reg;
    logic [COORD_WIDTH-1:0] rem_reg;
    logic [QRW-1:0]         q_reg;
    logic                   nbit;
    logic [COORD_WIDTH:0]   trial;
    logic [COORD_WIDTH:0]   diff;
    logic                   fits;

    always_comb begin
        // the dividend has a single one, at its top bit
        nbit  = (cnt_reg == CNT_W'(QW - 1));
        trial = {rem_reg, nbit};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QW - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
            q_reg   <= {q_reg[QRW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = (|q_reg[QRW-1:COORD_WIDTH]) ? '1 : q_reg[COORD_WIDTH-1:0];

endmodule

/* rtl/core/bbn_checker.sv */
// Port-level checker for the vertex bounding box normaliser, bound to the top level.
// Depends on the top level's ports only.

module bbn_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int OUT_TW      = 320
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tlast,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [OUT_TW-1:0] m_tdata,
    input logic              m_tuser,
    input logic              m_tvalid,
    input logic              m_tready
);

    localparam int SC_LO = 9 * COORD_WIDTH - 6;

    logic [COORD_WIDTH-1:0] scale;
    assign scale = m_tdata[SC_LO +: COORD_WIDTH];

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Never take a vertex while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // Close the input after the last vertex of a frame
    a_close_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("vertex accepted right after frame end");

    // One result per frame
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("second result without a new frame");

    // A zero box carries a zero reciprocal
    a_zero_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> scale == '0)
        else $error("zero extent with nonzero reciprocal");

endmodule

bind vertex_bounding_box_normaliser bbn_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .OUT_TW      (OUT_TW)
) u_bbn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
